[rtl/core/bchc_pkg.sv]
// Shared types and constants for the button click and hold classifier.
package bchc_pkg;

  // Input commands
  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_POLL    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_HOLD_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_CLICK_GAP      = 2'd1;
  localparam logic [1:0] REG_HOLD_PERIOD    = 2'd2;

  // Configuration reset values
  localparam logic [15:0] HOLD_THRESHOLD_RST = 16'd1000;
  localparam logic [15:0] CLICK_GAP_RST      = 16'd400;
  localparam logic [15:0] HOLD_PERIOD_RST    = 16'd1000;

  // Saturation value of the click and hold counts
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // Number of quotient bits produced by the hold-step divider
  localparam int DIV_BITS = 8;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] clicks;
    logic [7:0] holds;
    logic       event_ready;
    logic       interacting;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       capture;   // latch the accepted item
    logic       load;      // form span, remainder and compare flags
    logic       div_step;  // one restoring-division step
    logic [2:0] bit_idx;   // quotient bit resolved by this step
    logic       finish;    // commit state update and load the result
  } dp_cmd_t;

endpackage

[rtl/core/bchc_ctrl.sv]
// Controller state machine: sequences capture, load, divide and finish.
module bchc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output bchc_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       fin;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;
  assign fin       = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // Drive datapath commands
  always_comb begin
    cmd.capture  = accept;
    cmd.load     = (state_r == S_LOAD);
    cmd.div_step = (state_r == S_DIV);
    cmd.bit_idx  = cnt_r;
    cmd.finish   = fin;
  end

  // Advance the sequence
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cnt_nxt   = 3'(bchc_pkg::DIV_BITS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (cnt_r == 3'd0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 3'd1;
        end
      end
      S_FIN: begin
        if (fin) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/bchc_dp.sv]
// Datapath: configuration, button state, hold-step divider and result register.
module bchc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  bchc_pkg::dp_cmd_t   cmd,
  input  bchc_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output bchc_pkg::out_item_t out_data
);

  // Configuration
  logic [15:0] thr_r, gap_r, period_r;
  // Button state
  logic        pressed_r, pressed_nxt;
  logic [31:0] fall_r, fall_nxt;
  logic [31:0] rise_r, rise_nxt;
  logic [7:0]  click_r, click_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        cp_r, cp_nxt;
  logic        hp_r, hp_nxt;
  // Captured item and divider
  logic [1:0]  cmd_r;
  logic [31:0] now_r;
  logic [23:0] rem_r;
  logic [7:0]  q_r;
  logic        sat_r, ge_r, gap_ok_r;
  bchc_pkg::out_item_t out_r, out_nxt;

  logic [15:0] per;
  logic [23:0] sat_lim;
  logic [31:0] span, diff;
  logic [23:0] per_sh;
  logic [7:0]  steps;
  logic        busy, hold_hit, active_after;
  logic [7:0]  hold_v;
  logic        hp_v;
  logic [7:0]  rep_clicks, rep_holds;

  // A zero period acts as one
  assign per     = (period_r == 16'd0) ? 16'd1 : period_r;
  // 255 * period: at or above this the step count saturates
  assign sat_lim = ({per, 8'd0}) - {8'd0, per};
  assign span    = now_r - fall_r;
  assign diff    = span - {16'd0, thr_r};
  assign per_sh  = {8'd0, per} << cmd.bit_idx;

  assign steps    = sat_r ? bchc_pkg::COUNT_MAX : (q_r + 8'd1);
  assign busy     = pressed_r || cp_r || hp_r;
  assign hold_hit = ge_r && (steps != hold_r);

  // Work out the state update and the reported counts
  always_comb begin
    pressed_nxt = pressed_r;
    fall_nxt    = fall_r;
    rise_nxt    = rise_r;
    click_nxt   = click_r;
    hold_nxt    = hold_r;
    cp_nxt      = cp_r;
    hp_nxt      = hp_r;
    hold_v      = hold_r;
    hp_v        = hp_r;
    rep_clicks  = 8'd0;
    rep_holds   = 8'd0;
    unique case (cmd_r)
      bchc_pkg::CMD_PRESS: begin
        if (!pressed_r) begin
          fall_nxt    = now_r;
          pressed_nxt = 1'b1;
          hold_nxt    = 8'd0;
          hp_nxt      = 1'b0;
        end
      end
      bchc_pkg::CMD_RELEASE: begin
        if (pressed_r) begin
          rise_nxt    = now_r;
          pressed_nxt = 1'b0;
          if (ge_r) begin
            if (hold_hit) begin
              hold_nxt = steps;
              hp_nxt   = 1'b1;
            end
          end else begin
            if (click_r != bchc_pkg::COUNT_MAX) click_nxt = click_r + 8'd1;
            cp_nxt = 1'b1;
          end
        end
      end
      bchc_pkg::CMD_POLL: begin
        if (busy) begin
          // report clicks once the gap has passed
          if (cp_r && gap_ok_r) begin
            rep_clicks = click_r;
            click_nxt  = 8'd0;
            cp_nxt     = 1'b0;
          end
          // refresh the hold count while held
          if (pressed_r && hold_hit) begin
            hold_v = steps;
            hp_v   = 1'b1;
          end
          if (hp_v) begin
            rep_holds = hold_v;
            if (!pressed_r) hold_v = 8'd0;
            hp_v = 1'b0;
          end
          hold_nxt = hold_v;
          hp_nxt   = hp_v;
        end else begin
          // idle poll: drop everything
          fall_nxt  = 32'd0;
          rise_nxt  = 32'd0;
          click_nxt = 8'd0;
          hold_nxt  = 8'd0;
          cp_nxt    = 1'b0;
          hp_nxt    = 1'b0;
        end
      end
      default: begin
      end
    endcase
    active_after        = pressed_nxt || cp_nxt || hp_nxt;
    out_nxt.clicks      = rep_clicks;
    out_nxt.holds       = rep_holds;
    out_nxt.event_ready = (rep_clicks != 8'd0) || (rep_holds != 8'd0);
    out_nxt.interacting = (cmd_r == bchc_pkg::CMD_POLL) ? busy : active_after;
  end

  // Configuration and button state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= bchc_pkg::HOLD_THRESHOLD_RST;
      gap_r     <= bchc_pkg::CLICK_GAP_RST;
      period_r  <= bchc_pkg::HOLD_PERIOD_RST;
      pressed_r <= 1'b0;
      fall_r    <= 32'd0;
      rise_r    <= 32'd0;
      click_r   <= 8'd0;
      hold_r    <= 8'd0;
      cp_r      <= 1'b0;
      hp_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bchc_pkg::REG_HOLD_THRESHOLD: thr_r    <= cfg_wdata;
          bchc_pkg::REG_CLICK_GAP:      gap_r    <= cfg_wdata;
          bchc_pkg::REG_HOLD_PERIOD:    period_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.finish) begin
        pressed_r <= pressed_nxt;
        fall_r    <= fall_nxt;
        rise_r    <= rise_nxt;
        click_r   <= click_nxt;
        hold_r    <= hold_nxt;
        cp_r      <= cp_nxt;
        hp_r      <= hp_nxt;
      end
    end
  end

  // Capture the item, set up and run the divider, load the result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_data.command;
      now_r <= in_data.time_ms;
    end
    if (cmd.load) begin
      ge_r     <= (span >= {16'd0, thr_r});
      sat_r    <= (diff >= {8'd0, sat_lim});
      gap_ok_r <= ((now_r - rise_r) >= {16'd0, gap_r});
      rem_r    <= diff[23:0];
      q_r      <= 8'd0;
    end
    if (cmd.div_step) begin
      if (rem_r >= per_sh) begin
        rem_r             <= rem_r - per_sh;
        q_r[cmd.bit_idx]  <= 1'b1;
      end
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

[rtl/core/button_click_hold_classifier_core.sv]
// Button click and hold classifier: takes press, release and poll items with
// a millisecond timestamp and returns one result item per input item. Each
// item passes through capture, forming the press span, eight steps of the
// bit-per-cycle divider that turns the span into a hold step count, and the
// commit of the update, before the next item can be accepted. Its result is
// loaded into the output register at the commit.
// A finished result waits in the output register while the block accepts the
// next item; the block only holds in its final cycle if that register is
// still full. Configuration writes take effect at once and must be made
// while no item is in flight.
module button_click_hold_classifier_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bchc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bchc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  bchc_pkg::dp_cmd_t cmd;

  bchc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bchc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

[rtl/core/bchc_checker.sv]
// Port-level checks for the button click and hold classifier.
module bchc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bchc_pkg::out_item_t out_data
);

  // An accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accepted item");

  // The event flag matches the reported counts
  a_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.event_ready ==
                   ((out_data.clicks != 8'd0) || (out_data.holds != 8'd0))))
    else $error("event_ready disagrees with reported counts");

  // An event is only reported while interacting
  a_event_interacting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_ready |-> out_data.interacting)
    else $error("event reported without interaction");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

bind button_click_hold_classifier_core bchc_checker u_bchc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[sim/tb_button_click_hold_classifier_core.sv]
// Self-checking testbench for the button click and hold classifier core.
`timescale 1ns / 100ps

module tb_button_click_hold_classifier_core;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int TARGET_ITEMS = 1950;
  localparam int DRAIN_PAD = 24;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int MAX_REPORTS = 10;

  localparam bchc_pkg::out_item_t RES_IDLE    = '{8'd0, 8'd0, 1'b0, 1'b0};
  localparam bchc_pkg::out_item_t RES_PRESSED = '{8'd0, 8'd0, 1'b0, 1'b1};

  typedef struct packed {
    logic [1:0]          cmd;
    logic [31:0]         t;
    logic                typed;
    bchc_pkg::out_item_t exp;
  } dir_row_t;

  // Directed rows at reset settings; typed results only right after reset
  localparam int N_DIR = 26;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{bchc_pkg::CMD_POLL,    32'h0000_0000, 1'b1, RES_IDLE},    // idle poll
    '{CMD_UNUSED,            32'hFFFF_FFFF, 1'b1, RES_IDLE},    // unused command
    '{bchc_pkg::CMD_RELEASE, 32'h0000_0005, 1'b1, RES_IDLE},    // release while released
    '{bchc_pkg::CMD_PRESS,   32'h0000_0064, 1'b1, RES_PRESSED},
    '{bchc_pkg::CMD_PRESS,   32'h0000_0096, 1'b0, RES_IDLE},    // press while pressed
    '{CMD_UNUSED,            32'h0000_00A0, 1'b0, RES_IDLE},
    '{bchc_pkg::CMD_RELEASE, 32'h0000_012C, 1'b0, RES_IDLE},    // short press: click
    '{bchc_pkg::CMD_POLL,    32'h0000_01F4, 1'b0, RES_IDLE},    // gap not yet over
    '{bchc_pkg::CMD_PRESS,   32'h0000_0258, 1'b0, RES_IDLE},
    '{bchc_pkg::CMD_RELEASE, 32'h0000_02BC, 1'b0, RES_IDLE},
    '{bchc_pkg::CMD_POLL,    32'h0000_044C, 1'b0, RES_IDLE},    // gap exactly over
    '{bchc_pkg::CMD_POLL,    32'h0000_04B0, 1'b0, RES_IDLE},
    '{bchc_pkg::CMD_PRESS,   32'hFFFF_FE00, 1'b0, RES_IDLE},    // press just before wrap
    '{bchc_pkg::CMD_POLL,    32'h0000_01E7, 1'b0, RES_IDLE},    // one below threshold
    '{bchc_pkg::CMD_POLL,    32'h0000_01E8, 1'b0, RES_IDLE},    // first hold step
    '{bchc_pkg::CMD_POLL,    32'h0000_05D0, 1'b0, RES_IDLE},    // second hold step
    '{bchc_pkg::CMD_RELEASE, 32'h0000_07C4, 1'b0, RES_IDLE},    // leave hold, same step
    '{bchc_pkg::CMD_POLL,    32'h0000_0900, 1'b0, RES_IDLE},
    '{bchc_pkg::CMD_PRESS,   32'h0000_4E20, 1'b0, RES_IDLE},
    '{bchc_pkg::CMD_RELEASE, 32'h0000_5BAC, 1'b0, RES_IDLE},    // long press, no polls
    '{bchc_pkg::CMD_POLL,    32'h0000_5C10, 1'b0, RES_IDLE},
    '{bchc_pkg::CMD_PRESS,   32'h1000_0000, 1'b0, RES_IDLE},
    '{bchc_pkg::CMD_POLL,    32'h1003_E418, 1'b0, RES_IDLE},    // hold count at maximum
    '{bchc_pkg::CMD_POLL,    32'h1004_97C8, 1'b0, RES_IDLE},    // saturated, nothing new
    '{bchc_pkg::CMD_RELEASE, 32'hFFFF_FFFF, 1'b0, RES_IDLE},
    '{bchc_pkg::CMD_POLL,    32'h0000_0000, 1'b0, RES_IDLE}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  bchc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  bchc_pkg::out_item_t out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // Predictor state and register copies
  logic [15:0] thr_ms;
  logic [15:0] gap_ms;
  logic [15:0] per_ms;
  logic        btn_down;
  logic [31:0] press_ts;
  logic [31:0] release_ts;
  logic [7:0]  click_cnt;
  logic [7:0]  hold_cnt;
  logic        click_pend;
  logic        hold_pend;

  bchc_pkg::out_item_t expected_q[$];
  logic [31:0] now_ms;
  int          items_sent;
  int          mismatch_cnt;
  int          cycle_cnt;

  // Receiver stall control
  int          rx_run;
  logic        rx_stall_mode;
  int          rx_hold_left;
  bit          rx_hold_req;

  button_click_hold_classifier_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic button_busy();
    return btn_down || click_pend || hold_pend;
  endfunction

  // Advance the hold step count from the press span
  function automatic void advance_hold(input logic [31:0] t, input logic leaving);
    logic [31:0] span;
    logic [31:0] per;
    logic [31:0] q;
    logic [7:0]  steps;
    if (!btn_down && !leaving) return;
    span = t - press_ts;
    if (span < {16'd0, thr_ms}) return;
    per = (per_ms == 16'd0) ? 32'd1 : {16'd0, per_ms};
    q = (span - {16'd0, thr_ms}) / per;
    steps = (q >= 32'd255) ? bchc_pkg::COUNT_MAX : q[7:0] + 8'd1;
    if (steps == hold_cnt) return;
    hold_cnt = steps;
    hold_pend = 1'b1;
  endfunction

  // Compute the result of one item and update the button state
  function automatic bchc_pkg::out_item_t predict_button(input bchc_pkg::in_item_t it);
    bchc_pkg::out_item_t r;
    logic [31:0]         t;
    logic [31:0]         since_rel;
    logic                active;
    t = it.time_ms;
    r = '0;
    case (it.command)
      bchc_pkg::CMD_PRESS: begin
        if (!btn_down) begin
          press_ts = t;
          btn_down = 1'b1;
          hold_cnt = '0;
          hold_pend = 1'b0;
        end
        active = button_busy();
      end
      bchc_pkg::CMD_RELEASE: begin
        if (btn_down) begin
          release_ts = t;
          btn_down = 1'b0;
          if (t - press_ts >= {16'd0, thr_ms}) begin
            advance_hold(t, 1'b1);
          end else begin
            if (click_cnt != bchc_pkg::COUNT_MAX) click_cnt = click_cnt + 8'd1;
            click_pend = 1'b1;
          end
        end
        active = button_busy();
      end
      bchc_pkg::CMD_POLL: begin
        active = button_busy();
        if (active) begin
          since_rel = t - release_ts;
          if (click_pend && since_rel >= {16'd0, gap_ms}) begin
            r.clicks = click_cnt;
            click_cnt = '0;
            click_pend = 1'b0;
          end
          advance_hold(t, 1'b0);
          if (hold_pend) begin
            r.holds = hold_cnt;
            if (!btn_down) hold_cnt = '0;
            hold_pend = 1'b0;
          end
        end else begin
          press_ts = '0;
          release_ts = '0;
          click_cnt = '0;
          hold_cnt = '0;
          click_pend = 1'b0;
          hold_pend = 1'b0;
        end
      end
      default: begin
        active = button_busy();
      end
    endcase
    r.event_ready = (r.clicks != 8'd0) || (r.holds != 8'd0);
    r.interacting = active;
    return r;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (rx_hold_left > 0) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Pick a delta at or around a boundary
  function automatic logic [31:0] near(input logic [31:0] base);
    case ($urandom_range(0, 4))
      0: return base - 32'd1;
      1: return base;
      2: return base + 32'd1;
      3: return $urandom_range(0, base);
      default: return base + $urandom_range(0, base + 1);
    endcase
  endfunction

  // Offer one item, predict it on acceptance, then maybe idle
  task automatic offer_item(input logic [1:0] cmd, input logic [31:0] t,
                            input logic typed, input bchc_pkg::out_item_t typed_res);
    bchc_pkg::in_item_t  it;
    bchc_pkg::out_item_t p;
    int                  gap;
    it.command = cmd;
    it.time_ms = t;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_button(it);
    expected_q.push_back(typed ? typed_res : p);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic step_item(input logic [1:0] cmd, input logic [31:0] dt);
    now_ms = now_ms + dt;
    offer_item(cmd, now_ms, 1'b0, RES_IDLE);
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Write all registers plus the unused index
  task automatic set_config(input logic [15:0] thr, input logic [15:0] gap,
                            input logic [15:0] per);
    cfg_we <= 1'b1;
    cfg_index <= bchc_pkg::REG_HOLD_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_index <= bchc_pkg::REG_CLICK_GAP;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_index <= bchc_pkg::REG_HOLD_PERIOD;
    cfg_wdata <= per;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= 16'($urandom_range(0, 65535));
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_ms = thr;
    gap_ms = gap;
    per_ms = per;
  endtask

  function automatic logic [31:0] press_length();
    if (thr_ms == 16'd0) return $urandom_range(0, 50);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, thr_ms - 16'd1);
    return near({16'd0, thr_ms});
  endfunction

  // A burst of short presses followed by polls around the click gap
  task automatic click_burst();
    int k;
    int n_poll;
    k = $urandom_range(1, 4);
    for (int i = 0; i < k; i++) begin
      step_item(bchc_pkg::CMD_PRESS,
                (i == 0) ? $urandom_range(0, 3 * gap_ms + 10)
                         : $urandom_range(0, gap_ms + gap_ms / 2 + 2));
      if ($urandom_range(0, 3) == 0) step_item(bchc_pkg::CMD_POLL, $urandom_range(0, 5));
      step_item(bchc_pkg::CMD_RELEASE, press_length());
    end
    n_poll = $urandom_range(0, 2);
    for (int i = 0; i < n_poll; i++)
      step_item(bchc_pkg::CMD_POLL, $urandom_range(0, gap_ms / 2 + 2));
    step_item(bchc_pkg::CMD_POLL, near({16'd0, gap_ms}));
    if ($urandom_range(0, 1) == 0)
      step_item(bchc_pkg::CMD_POLL, $urandom_range(0, gap_ms + 2));
  endtask

  // A long press polled across the threshold and the hold steps
  task automatic long_press();
    int          m;
    logic [31:0] per;
    per = (per_ms == 16'd0) ? 32'd1 : {16'd0, per_ms};
    step_item(bchc_pkg::CMD_PRESS, $urandom_range(0, 2 * gap_ms + 20));
    step_item(bchc_pkg::CMD_POLL, near({16'd0, thr_ms}));
    m = $urandom_range(0, 4);
    for (int i = 0; i < m; i++) begin
      if ($urandom_range(0, 9) == 0) step_item(bchc_pkg::CMD_POLL, near(per * 255));
      else step_item(bchc_pkg::CMD_POLL, near(per * $urandom_range(1, 2)));
    end
    step_item(bchc_pkg::CMD_RELEASE, near(per));
    step_item(bchc_pkg::CMD_POLL, near({16'd0, gap_ms}));
    if ($urandom_range(0, 1) == 0)
      step_item(bchc_pkg::CMD_POLL, $urandom_range(0, gap_ms + 2));
  endtask

  // A press and release with repeated edges mixed in
  task automatic broken_sequence();
    step_item(bchc_pkg::CMD_PRESS, $urandom_range(0, gap_ms + 20));
    if ($urandom_range(0, 1) == 0) step_item(bchc_pkg::CMD_PRESS, $urandom_range(0, 10));
    step_item(bchc_pkg::CMD_RELEASE, near({16'd0, thr_ms}));
    if ($urandom_range(0, 1) == 0) step_item(bchc_pkg::CMD_RELEASE, $urandom_range(0, 10));
    if ($urandom_range(0, 2) == 0) step_item(CMD_UNUSED, $urandom_range(0, 10));
    step_item(bchc_pkg::CMD_POLL, near({16'd0, gap_ms}));
  endtask

  task automatic noise_items();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        step_item(2'($urandom_range(0, 3)), $urandom());
      else
        step_item(2'($urandom_range(0, 3)),
                  $urandom_range(0, 2 * thr_ms + 2 * gap_ms + 10));
    end
  endtask

  task automatic random_phase(input int n);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 40) click_burst();
      else if (r < 75) long_press();
      else if (r < 90) broken_sequence();
      else noise_items();
    end
  endtask

  // Many short presses with no poll, to drive the click count toward saturation
  task automatic click_storm();
    for (int i = 0; i < 260; i++) begin
      step_item(bchc_pkg::CMD_PRESS, $urandom_range(0, 5));
      step_item(bchc_pkg::CMD_RELEASE, press_length());
    end
    step_item(bchc_pkg::CMD_POLL, {16'd0, gap_ms} + $urandom_range(0, 5));
  endtask

  // Receiver: random stall runs, plus one long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left = 400;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        case ($urandom_range(0, 99)) inside
          [0:54]: begin
            rx_stall_mode = 1'b0;
            rx_run = $urandom_range(1, 40);
          end
          [55:89]: begin
            rx_stall_mode = 1'b1;
            rx_run = $urandom_range(1, 3);
          end
          [90:96]: begin
            rx_stall_mode = 1'b1;
            rx_run = $urandom_range(4, 12);
          end
          default: begin
            rx_stall_mode = 1'b1;
            rx_run = $urandom_range(20, 60);
          end
        endcase
      end
      rx_run--;
      out_stall <= rx_stall_mode;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    bchc_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result: clicks=%0d holds=%0d ev=%b act=%b",
                                out_data.clicks, out_data.holds, out_data.event_ready,
                                out_data.interacting));
      end else begin
        want = expected_q.pop_front();
        if (out_data.clicks !== want.clicks || out_data.holds !== want.holds ||
            out_data.event_ready !== want.event_ready ||
            out_data.interacting !== want.interacting) begin
          note_mismatch($sformatf(
            {"mismatch: expected clicks=%0d holds=%0d ev=%b act=%b, ",
             "got clicks=%0d holds=%0d ev=%b act=%b"},
            want.clicks, want.holds, want.event_ready, want.interacting,
            out_data.clicks, out_data.holds, out_data.event_ready, out_data.interacting));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= bchc_pkg::REG_HOLD_THRESHOLD;
    cfg_wdata <= '0;
    rx_run = 0;
    rx_stall_mode = 1'b0;
    rx_hold_left = 0;
    rx_hold_req = 1'b0;
    items_sent = 0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    now_ms = '0;
    thr_ms = bchc_pkg::HOLD_THRESHOLD_RST;
    gap_ms = bchc_pkg::CLICK_GAP_RST;
    per_ms = bchc_pkg::HOLD_PERIOD_RST;
    btn_down = 1'b0;
    press_ts = '0;
    release_ts = '0;
    click_cnt = '0;
    hold_cnt = '0;
    click_pend = 1'b0;
    hold_pend = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset settings
    for (int i = 0; i < N_DIR; i++)
      offer_item(DIR_TAB[i].cmd, DIR_TAB[i].t, DIR_TAB[i].typed, DIR_TAB[i].exp);
    drain_results();

    now_ms = 32'h0000_1000;
    random_phase(250);
    drain_results();

    // Lower extremes: zero threshold, zero gap, zero period
    set_config(16'd0, 16'd0, 16'd0);
    random_phase(250);
    drain_results();

    // Upper extremes near the time wrap, with a long receiver hold-off
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    now_ms = 32'hFFFF_0000;
    rx_hold_req = 1'b1;
    random_phase(250);
    drain_results();

    // Small settings and a click count driven toward saturation
    set_config(16'd20, 16'd10, 16'd3);
    click_storm();
    random_phase(150);
    drain_results();

    set_config(16'd1, 16'd0, 16'd1);
    random_phase(200);
    drain_results();

    // Random settings until enough items have gone through
    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 3) == 0)
        set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
      else
        set_config(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 1000)),
                   16'($urandom_range(0, 2000)));
      if ($urandom_range(0, 3) == 0) now_ms = $urandom();
      random_phase(200);
      drain_results();
    end

    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/bchc_pkg.sv
rtl/core/bchc_ctrl.sv
rtl/core/bchc_dp.sv
rtl/core/button_click_hold_classifier_core.sv
rtl/core/bchc_checker.sv
sim/tb_button_click_hold_classifier_core.sv
